// ----- src/modrtu_pkg.sv -----
// shared types, codes and crc helper for the modbus rtu master framer
`default_nettype none

package modrtu_pkg;

	// input item codes carried in tuser
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_RESP  = 2'd2
	} op_t;

	// result kinds carried in tuser
	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_WORD   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	localparam logic [7:0]  FUNC_WRITE_REG = 8'd6;
	localparam logic [7:0]  FUNC_READ_REGS = 8'd3;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
	localparam int unsigned MAX_READ_WORDS = 125;
	localparam logic [7:0]  RESP_OVERHEAD  = 8'd5;

	// one byte emitted by the frame serializer
	typedef struct packed {
		logic       fire;
		logic       last;
		logic [7:0] data;
	} tx_emit_t;

	// result produced by the response decoder
	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [15:0] word;
		logic        ok;
	} rx_result_t;

	// crc-16/modbus update by one byte, lsb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/modrtu_tx.sv -----
// request frame serializer: six header bytes then the crc, one byte per cycle while advance is high
`default_nettype none

module modrtu_tx
	import modrtu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire logic [7:0]  slave_addr,
	input  wire logic [7:0]  func,
	input  wire logic [15:0] reg_addr,
	input  wire logic [15:0] value,
	input  wire logic        advance,
	output logic             busy,
	output tx_emit_t         emit
);

	logic [7:0]  bytes_q [0:5];
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic        busy_q;
	logic [7:0]  cur_byte;
	logic        fire;

	// pick the byte at the current frame position
	always_comb begin
		case (idx_q)
			3'd6:    cur_byte = crc_q[7:0];
			3'd7:    cur_byte = crc_q[15:8];
			default: cur_byte = bytes_q[idx_q];
		endcase
	end

	assign fire      = busy_q && advance;
	assign busy      = busy_q;
	assign emit.fire = fire;
	assign emit.last = (idx_q == 3'd7);
	assign emit.data = cur_byte;

	// position and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (fire) begin
			idx_q <= idx_q + 3'd1;
			if (idx_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	// frame bytes and running crc over the header
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q[0] <= slave_addr;
			bytes_q[1] <= func;
			bytes_q[2] <= reg_addr[15:8];
			bytes_q[3] <= reg_addr[7:0];
			bytes_q[4] <= value[15:8];
			bytes_q[5] <= value[7:0];
			crc_q      <= CRC_INIT;
		end else if (fire && idx_q < 3'd6) begin
			crc_q <= crc_byte(crc_q, cur_byte);
		end
	end

	// checks
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == 3'd0)
		else $error("serializer did not start at byte zero after load");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && idx_q == 3'd7 && !load) |=> !busy_q)
		else $error("serializer still busy after last byte");
	a_rose_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(load))
		else $error("serializer became busy without a load");

endmodule

`default_nettype wire

// ----- src/modrtu_rx.sv -----
// response decoder: running crc, word pairing and crc status
`default_nettype none

module modrtu_rx
	import modrtu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       arm,
	input  wire logic [7:0] arm_len,
	input  wire logic       byte_valid,
	input  wire logic [7:0] rx_byte,
	output rx_result_t      result
);

	logic        pending_q;
	logic [7:0]  len_q;
	logic [7:0]  pos_q;
	logic [15:0] crc_q;
	logic [7:0]  held_q;
	logic [7:0]  crc_lo_q;
	logic [8:0]  pos_plus2;
	logic [8:0]  len_ext;
	logic        take;

	assign pos_plus2 = {1'b0, pos_q} + 9'd2;
	assign len_ext   = {1'b0, len_q};
	assign take      = byte_valid && pending_q;

	// result for the byte being taken
	always_comb begin
		result.valid = 1'b0;
		result.kind  = KIND_WORD;
		result.word  = 16'd0;
		result.ok    = 1'b0;
		if (take) begin
			if (pos_plus2 < len_ext) begin
				if (pos_q >= 8'd3 && !pos_q[0]) begin
					result.valid = 1'b1;
					result.word  = {held_q, rx_byte};
				end
			end else if (pos_plus2 != len_ext) begin
				result.valid = 1'b1;
				result.kind  = KIND_STATUS;
				result.ok    = ({rx_byte, crc_lo_q} == crc_q);
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			len_q     <= 8'd0;
			pos_q     <= 8'd0;
			crc_q     <= CRC_INIT;
			held_q    <= 8'd0;
			crc_lo_q  <= 8'd0;
		end else if (arm) begin
			pending_q <= 1'b1;
			len_q     <= arm_len;
			pos_q     <= 8'd0;
			crc_q     <= CRC_INIT;
			held_q    <= 8'd0;
			crc_lo_q  <= 8'd0;
		end else if (take) begin
			pos_q <= pos_q + 8'd1;
			if (pos_plus2 < len_ext) begin
				crc_q <= crc_byte(crc_q, rx_byte);
				if (pos_q >= 8'd3 && pos_q[0]) begin
					held_q <= rx_byte;
				end
			end else if (pos_plus2 == len_ext) begin
				crc_lo_q <= rx_byte;
			end else begin
				pending_q <= 1'b0;
			end
		end
	end

	// checks
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> pos_q < len_q)
		else $error("response position ran past expected length");
	a_arm_resets: assert property (@(posedge clk) disable iff (!arst_n)
		arm |=> pending_q && pos_q == 8'd0 && crc_q == CRC_INIT)
		else $error("decoder not re-armed after read request");
	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind == KIND_STATUS && !arm) |=> !pending_q)
		else $error("decoder still pending after status");

endmodule

`default_nettype wire

// ----- src/modbus_rtu_master_framer.sv -----
// modbus rtu master framer top level: input stage, serializer, decoder, output register
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+-----------------------------------
//  cfg     | in        | cfg_valid / cfg_ready          | cfg_data = slave address
//  s_axis  | in        | s_axis_tvalid / s_axis_tready  | tuser = operation, tdata = fields
//  m_axis  | out       | m_axis_tvalid / m_axis_tready  | tuser = kind, tlast, tdata = fields
//
// a request occupies the serializer for its eight frame bytes, one frame byte per cycle
// while the output is not stalled; the crc is folded in one byte per cycle as the header bytes leave.
// a request passes the stage register and the serializer before its first frame byte enters the output register.
// a response byte is decoded combinationally from the stage register into the output register.
// reset clears all control state, the decoder and sets the slave address to 1.
// m_axis_tready low freezes the output register and the serializer; input keeps
// one item in the stage register and then holds off.
`default_nettype none

module modbus_rtu_master_framer
	import modrtu_pkg::*;
#(
	parameter int unsigned MAX_WORDS = MAX_READ_WORDS
)
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// reg_address[15:0], write_value[31:16], word_count[38:32], rx_byte[46:39], zero
	input  wire logic [47:0] s_axis_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tx_byte[7:0], rx_word[23:8], crc_ok[24], zero
	output logic [31:0]      m_axis_tdata,
	// kind[1:0]
	output logic [1:0]       m_axis_tuser,
	output logic             m_axis_tlast
);

	logic [7:0]  slave_q;

	logic        valid_s1;
	op_t         op_s1;
	logic [15:0] addr_s1;
	logic [15:0] val_s1;
	logic [6:0]  cnt_s1;
	logic [7:0]  byte_s1;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  tx_q;
	logic [15:0] word_q;
	logic        ok_q;
	logic        last_q;

	logic        out_free;
	logic        tx_busy;
	tx_emit_t    tx_emit;
	logic        tx_done;
	logic        take_s1;
	logic        is_req;
	logic        load;
	logic [6:0]  n_clamped;
	logic [7:0]  func;
	logic [15:0] value;
	logic [7:0]  arm_len;
	logic        rx_take;
	rx_result_t  rx_res;
	logic        in_fire;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q <= SLAVE_ADDR_RST;
		end else if (cfg_valid) begin
			slave_q <= cfg_data;
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign tx_done  = tx_emit.fire && tx_emit.last;

	// when the stage register can hand its item on
	always_comb begin
		is_req = 1'b0;
		case (op_s1)
			OP_WRITE: begin
				take_s1 = !tx_busy || tx_done;
				is_req  = 1'b1;
			end
			OP_READ: begin
				take_s1 = !tx_busy || tx_done;
				is_req  = 1'b1;
			end
			OP_RESP:  take_s1 = !tx_busy && out_free;
			default:  take_s1 = 1'b1;
		endcase
	end

	assign s_axis_tready = !valid_s1 || take_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op_t'(s_axis_tuser);
			addr_s1 <= s_axis_tdata[15:0];
			val_s1  <= s_axis_tdata[31:16];
			cnt_s1  <= s_axis_tdata[38:32];
			byte_s1 <= s_axis_tdata[46:39];
		end
	end

	// request frame fields, word count clamped to the legal range
	always_comb begin
		if (cnt_s1 == 7'd0) begin
			n_clamped = 7'd1;
		end else if (cnt_s1 > 7'(MAX_WORDS)) begin
			n_clamped = 7'(MAX_WORDS);
		end else begin
			n_clamped = cnt_s1;
		end
	end

	assign load    = valid_s1 && take_s1 && is_req;
	assign func    = (op_s1 == OP_READ) ? FUNC_READ_REGS : FUNC_WRITE_REG;
	assign value   = (op_s1 == OP_READ) ? {9'd0, n_clamped} : val_s1;
	assign arm_len = {n_clamped, 1'b0} + RESP_OVERHEAD;
	assign rx_take = valid_s1 && take_s1 && (op_s1 == OP_RESP);

	modrtu_tx u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.slave_addr (slave_q),
		.func       (func),
		.reg_addr   (addr_s1),
		.value      (value),
		.advance    (out_free),
		.busy       (tx_busy),
		.emit       (tx_emit)
	);

	modrtu_rx u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.arm        (load && op_s1 == OP_READ),
		.arm_len    (arm_len),
		.byte_valid (rx_take),
		.rx_byte    (byte_s1),
		.result     (rx_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= tx_emit.fire || rx_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (tx_emit.fire) begin
				kind_q <= KIND_TX;
				tx_q   <= tx_emit.data;
				word_q <= 16'd0;
				ok_q   <= 1'b0;
				last_q <= tx_emit.last;
			end else begin
				kind_q <= rx_res.kind;
				tx_q   <= 8'd0;
				word_q <= rx_res.word;
				ok_q   <= rx_res.ok;
				last_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {7'd0, ok_q, word_q, tx_q};

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rx_res.valid |-> !tx_busy)
		else $error("decoder result while serializer busy");
	a_load_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(load && tx_busy) |-> tx_done)
		else $error("frame loaded over a frame in flight");
	a_rx_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_TX) |-> m_axis_tlast)
		else $error("decoder result not marked last");

endmodule

`default_nettype wire

// ----- dv/modbus_rtu_master_framer_test.sv -----
// testbench for the modbus rtu master framer: directed and random traffic checked against a built-in predictor
module modbus_rtu_master_framer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import modrtu_pkg::*;

	// operation code the block must ignore
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	// cycles without any handshake before the run is declared hung
	localparam int QUIET_LIMIT = 1000;
	// cycles allowed for in-flight work after the last expected result
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] reg_address;
		logic [15:0] write_value;
		logic [6:0]  word_count;
		logic [7:0]  rx_byte;
	} in_item_t;

	typedef struct {
		kind_t       kind;
		logic [7:0]  tx_byte;
		logic [15:0] rx_word;
		logic        crc_ok;
		logic        last;
	} out_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// reg_address[15:0], write_value[31:16], word_count[38:32], rx_byte[46:39], zero
	logic [47:0] s_axis_tdata = '0;
	// operation[1:0]
	logic [1:0]  s_axis_tuser = 2'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tx_byte[7:0], rx_word[23:8], crc_ok[24], zero
	logic [31:0] m_axis_tdata;
	// kind[1:0]
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	modbus_rtu_master_framer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	in_item_t  req_items[$];
	out_item_t due_results[$];
	in_item_t  on_bus;
	int        n_offered = 0;
	int        n_accepted = 0;
	int        n_errors = 0;
	int        src_gap = 0;
	int        sink_stall = 0;
	int        idle_odds = 4;
	int        quiet_cycles = 0;

	// predictor copy of the slave address and of the response decoder
	logic [7:0]  slave_addr = SLAVE_ADDR_RST;
	logic        rsp_armed = 1'b0;
	logic [7:0]  rsp_len = 8'd0;
	logic [7:0]  rsp_pos = 8'd0;
	logic [15:0] rsp_crc = 16'hFFFF;
	logic [7:0]  rsp_high = 8'd0;
	logic [7:0]  rsp_crc_low = 8'd0;

	// crc-16/modbus, one byte shifted out lsb first
	function automatic logic [15:0] crc16_modbus(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		logic        lsb;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			lsb = c[0];
			c = {1'b0, c[15:1]};
			if (lsb) begin
				c = c ^ 16'hA001;
			end
		end
		return c;
	endfunction

	function automatic void expect_out(kind_t k, logic [7:0] tx, logic [15:0] w, logic ok,
			logic lst);
		out_item_t r;
		r.kind = k;
		r.tx_byte = tx;
		r.rx_word = w;
		r.crc_ok = ok;
		r.last = lst;
		due_results.push_back(r);
	endfunction

	// eight request bytes with the crc appended low byte first
	function automatic void expect_frame(logic [7:0] func, logic [15:0] addr, logic [15:0] val);
		logic [7:0]  f[8];
		logic [15:0] crc;
		f[0] = slave_addr;
		f[1] = func;
		f[2] = addr[15:8];
		f[3] = addr[7:0];
		f[4] = val[15:8];
		f[5] = val[7:0];
		crc = 16'hFFFF;
		for (int i = 0; i < 6; i++) begin
			crc = crc16_modbus(crc, f[i]);
		end
		f[6] = crc[7:0];
		f[7] = crc[15:8];
		for (int i = 0; i < 8; i++) begin
			expect_out(KIND_TX, f[i], 16'd0, 1'b0, i == 7);
		end
	endfunction

	// advance the predicted framer by one accepted request
	function automatic void framer_step(in_item_t it);
		int         p;
		int         len;
		logic [6:0] n;
		case (it.op)
			OP_WRITE: begin
				expect_frame(FUNC_WRITE_REG, it.reg_address, it.write_value);
			end
			OP_READ: begin
				n = it.word_count;
				if (n < 7'd1) begin
					n = 7'd1;
				end
				if (n > 7'(MAX_READ_WORDS)) begin
					n = 7'(MAX_READ_WORDS);
				end
				rsp_armed = 1'b1;
				rsp_len = {n, 1'b0} + RESP_OVERHEAD;
				rsp_pos = 8'd0;
				rsp_crc = 16'hFFFF;
				rsp_high = 8'd0;
				rsp_crc_low = 8'd0;
				expect_frame(FUNC_READ_REGS, it.reg_address, {9'd0, n});
			end
			OP_RESP: begin
				if (rsp_armed) begin
					p = rsp_pos;
					len = rsp_len;
					rsp_pos = rsp_pos + 8'd1;
					if (p + 2 < len) begin
						rsp_crc = crc16_modbus(rsp_crc, it.rx_byte);
						// data bytes pair into big-endian words
						if (p >= 3) begin
							if (((p - 3) & 1) == 0) begin
								rsp_high = it.rx_byte;
							end else begin
								expect_out(KIND_WORD, 8'd0, {rsp_high, it.rx_byte}, 1'b0, 1'b1);
							end
						end
					end else if (p + 2 == len) begin
						rsp_crc_low = it.rx_byte;
					end else begin
						rsp_armed = 1'b0;
						expect_out(KIND_STATUS, 8'd0, 16'd0,
							{it.rx_byte, rsp_crc_low} == rsp_crc, 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic bit roll_idle();
		return idle_odds != 0 && $urandom_range(1, idle_odds) == 1;
	endfunction

	function automatic in_item_t make_item(logic [1:0] op);
		in_item_t it;
		it.op = op;
		it.reg_address = 16'($urandom_range(0, 65535));
		it.write_value = 16'($urandom_range(0, 65535));
		it.word_count = 7'($urandom_range(0, 127));
		it.rx_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic void offer(in_item_t it);
		req_items.push_back(it);
		n_offered++;
	endfunction

	function automatic void offer_request(logic [1:0] op, logic [15:0] addr, logic [15:0] val,
			logic [6:0] n);
		in_item_t it;
		it = make_item(op);
		it.reg_address = addr;
		it.write_value = val;
		it.word_count = n;
		offer(it);
	endfunction

	function automatic void offer_byte(logic [7:0] b);
		in_item_t it;
		it = make_item(OP_RESP);
		it.rx_byte = b;
		offer(it);
	endfunction

	// response to a read of n words; fill < 0 gives random data, keep cuts it short
	function automatic void offer_response(int n, bit good, int keep, int fill);
		logic [7:0]  b[$];
		logic [15:0] crc;
		int          idx;
		b.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : slave_addr);
		b.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : FUNC_READ_REGS);
		b.push_back(8'(2 * n));
		for (int i = 0; i < 2 * n; i++) begin
			b.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
		end
		crc = 16'hFFFF;
		foreach (b[i]) begin
			crc = crc16_modbus(crc, b[i]);
		end
		b.push_back(crc[7:0]);
		b.push_back(crc[15:8]);
		// a single flipped bit always breaks the crc
		if (!good) begin
			idx = $urandom_range(0, b.size() - 1);
			b[idx] = b[idx] ^ (8'd1 << $urandom_range(0, 7));
		end
		for (int i = 0; i < b.size() && i < keep; i++) begin
			offer_byte(b[i]);
		end
	endfunction

	// wait until every request is taken and every result is back, then let the block drain
	task automatic settle();
		while (!(n_accepted == n_offered && due_results.size() == 0)) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		slave_addr = value;
	endtask

	task automatic random_traffic(int target);
		int counted;
		int pick;
		int n;
		int clamped;
		int keep;
		counted = 0;
		while (counted < target) begin
			pick = $urandom_range(0, 99);
			n = $urandom_range(0, 99);
			if (n < 3) begin
				n = $urandom_range(0, 1) ? MAX_READ_WORDS : $urandom_range(100, 127);
			end else if (n < 12) begin
				n = $urandom_range(0, 127);
			end else begin
				n = $urandom_range(1, 8);
			end
			clamped = n < 1 ? 1 : (n > MAX_READ_WORDS ? MAX_READ_WORDS : n);
			if (pick < 45) begin
				// complete read transaction
				offer_request(OP_READ, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					7'(n));
				offer_response(clamped, $urandom_range(0, 4) != 0, 1000, -1);
				counted += 2 * clamped + 6;
			end else if (pick < 60) begin
				// response cut short, left for the next read to abandon
				keep = $urandom_range(1, 2 * clamped + 4);
				offer_request(OP_READ, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					7'(n));
				offer_response(clamped, 1'b1, keep, -1);
				counted += keep + 1;
			end else if (pick < 85) begin
				offer(make_item(OP_WRITE));
				counted++;
			end else if (pick < 95) begin
				keep = $urandom_range(1, 3);
				repeat (keep) offer(make_item(OP_RESP));
				counted += keep;
			end else begin
				offer(make_item(OP_UNKNOWN));
				counted++;
			end
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				framer_step(on_bus);
				n_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (roll_idle()) begin
					src_gap = $urandom_range(0, 13);
					s_axis_tvalid <= 1'b0;
				end else if (req_items.size() > 0) begin
					on_bus = req_items.pop_front();
					s_axis_tdata <= {1'b0, on_bus.rx_byte, on_bus.word_count, on_bus.write_value,
						on_bus.reg_address};
					s_axis_tuser <= on_bus.op;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endtask

	// result monitor and output stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: kind %0h data %0h", m_axis_tuser, m_axis_tdata);
					n_errors++;
				end else begin
					check_field("kind", 16'(due_results[0].kind), 16'(m_axis_tuser));
					check_field("tx_byte", 16'(due_results[0].tx_byte), 16'(m_axis_tdata[7:0]));
					check_field("rx_word", due_results[0].rx_word, m_axis_tdata[23:8]);
					check_field("crc_ok", 16'(due_results[0].crc_ok), 16'(m_axis_tdata[24]));
					check_field("last", 16'(due_results[0].last), 16'(m_axis_tlast));
					void'(due_results.pop_front());
				end
			end
			if (sink_stall > 0) begin
				sink_stall--;
				m_axis_tready <= 1'b0;
			end else if (roll_idle()) begin
				sink_stall = $urandom_range(0, 13);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// hang detection: too long without any handshake
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, clamping, abandon, bad crc, stray and unknown items
		offer_request(OP_WRITE, 16'h0000, 16'h0000, 7'd0);
		offer_request(OP_WRITE, 16'hFFFF, 16'hFFFF, 7'd127);
		offer_request(OP_READ, 16'h1234, 16'hFFFF, 7'd0);
		offer_response(1, 1'b1, 1000, 8'h00);
		offer_request(OP_READ, 16'hFFFF, 16'h0000, 7'd127);
		offer_response(MAX_READ_WORDS, 1'b1, 3, 8'hFF);
		offer_request(OP_READ, 16'h0000, 16'h5A5A, 7'd2);
		offer_response(2, 1'b0, 1000, 8'hFF);
		offer_byte(8'hA5);
		offer(make_item(OP_UNKNOWN));
		settle();

		cfg_write(8'h00);
		idle_odds = 4;
		random_traffic(92);
		settle();

		cfg_write(8'hFF);
		idle_odds = 16;
		random_traffic(92);
		settle();

		cfg_write(8'($urandom_range(0, 255)));
		idle_odds = 3;
		random_traffic(92);
		settle();

		cfg_write(8'd247);
		idle_odds = 8;
		random_traffic(92);
		settle();

		// last stretch runs without idling on either side
		cfg_write(8'($urandom_range(0, 255)));
		idle_odds = 0;
		random_traffic(92);
		settle();

		if (n_errors == 0 && due_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
